// ===== hdl/p8cr_pkg.sv =====
// shared types, command codes and constants for the permutation unit
package p8cr_pkg;

    localparam int N_ELEM = 8;
    localparam int ENT_W  = 3;
    localparam int PERM_W = N_ELEM * ENT_W;
    localparam int RANK_W = 16;
    localparam int IDX_W  = 16;

    localparam logic [IDX_W-1:0] N_PERMS = 16'd40320;

    // reciprocals for exact floor division of narrow values by constants
    localparam logic [13:0] RECIP_7   = 14'd9363;   // >> 16, 13-bit operand
    localparam logic [12:0] RECIP_21  = 13'd6242;   // >> 17, 12-bit operand
    localparam logic [12:0] RECIP_105 = 13'd4994;   // >> 19, 12-bit operand
    localparam logic [10:0] RECIP_105_S = 11'd1249; // >> 17, 10-bit operand
    localparam logic [10:0] RECIP_315 = 11'd1665;   // >> 19, 10-bit operand

    // factorial-base weights of the lehmer digits, position 0 least significant
    localparam logic [RANK_W-1:0] RANK_WEIGHT [N_ELEM] = '{
        16'd1, 16'd8, 16'd56, 16'd336, 16'd1680, 16'd6720, 16'd20160, 16'd40320
    };

    typedef enum logic [2:0] {
        CMD_COMPOSE  = 3'd0,
        CMD_COMPOSE3 = 3'd1,
        CMD_INVERSE  = 3'd2,
        CMD_RANK     = 3'd3,
        CMD_UNRANK   = 3'd4,
        CMD_PARITY   = 3'd5
    } cmd_t;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [PERM_W-1:0] perm_a;
        logic [PERM_W-1:0] perm_b;
        logic [PERM_W-1:0] perm_c;
        logic [IDX_W-1:0]  perm_index;
    } op_beat_t;

    typedef struct packed {
        logic [PERM_W-1:0] perm_out;
        logic [RANK_W-1:0] rank_out;
        logic              odd_parity;
        logic              not_perm;
    } res_beat_t;

    function automatic logic [ENT_W-1:0] perm_entry(
        input logic [PERM_W-1:0] p,
        input logic [ENT_W-1:0]  i
    );
        perm_entry = ENT_W'(p >> (5'(i) * 5'd3));
    endfunction

endpackage

// ===== hdl/p8cr_unrank.sv =====
// lehmer decode: index modulo 40320 to a packed permutation
module p8cr_unrank (
    input  logic [p8cr_pkg::IDX_W-1:0]  perm_index,
    output logic [p8cr_pkg::PERM_W-1:0] perm
);
    import p8cr_pkg::*;

    logic [IDX_W-1:0] x;
    logic [12:0]      y;
    logic [11:0]      z;
    logic [9:0]       w;
    logic [26:0]      prod_56;
    logic [24:0]      prod_336;
    logic [24:0]      prod_1680;
    logic [20:0]      prod_6720;
    logic [20:0]      prod_20160;
    logic [9:0]       q56;
    logic [6:0]       q336;
    logic [4:0]       q1680;
    logic [2:0]       q6720;
    logic             q20160;
    logic [ENT_W-1:0] dig [N_ELEM];

    // one compare and subtract: the index is below twice the modulus
    assign x = (perm_index >= N_PERMS) ? perm_index - N_PERMS : perm_index;
    assign y = x[15:3];
    assign z = x[15:4];
    assign w = x[15:6];

    // every quotient comes straight from x, so the divides run side by side
    assign prod_56    = 27'(y) * 27'(RECIP_7);
    assign prod_336   = 25'(z) * 25'(RECIP_21);
    assign prod_1680  = 25'(z) * 25'(RECIP_105);
    assign prod_6720  = 21'(w) * 21'(RECIP_105_S);
    assign prod_20160 = 21'(w) * 21'(RECIP_315);

    assign q56    = prod_56[25:16];
    assign q336   = prod_336[23:17];
    assign q1680  = prod_1680[23:19];
    assign q6720  = prod_6720[19:17];
    assign q20160 = prod_20160[19];

    // mixed-radix digits, only the low three bits of each difference matter
    assign dig[0] = x[2:0];
    assign dig[1] = y[2:0] - q56[2:0] * 3'd7;
    assign dig[2] = q56[2:0] - q336[2:0] * 3'd6;
    assign dig[3] = q336[2:0] - q1680[2:0] * 3'd5;
    assign dig[4] = q1680[2:0] - q6720 * 3'd4;
    assign dig[5] = q6720 - {2'b00, q20160} * 3'd3;
    assign dig[6] = {2'b00, q20160};
    assign dig[7] = '0;

    // pick from the list of unused values and close the gap
    always_comb
    begin
        logic [ENT_W-1:0] avail [N_ELEM];
        perm = '0;
        for (int k = 0; k < N_ELEM; k++)
        begin
            avail[k] = ENT_W'(k);
        end
        for (int s = 0; s < N_ELEM; s++)
        begin
            perm[s*ENT_W +: ENT_W] = avail[dig[s]];
            for (int k = 0; k < N_ELEM - 1; k++)
            begin
                if (ENT_W'(k) >= dig[s])
                begin
                    avail[k] = avail[k+1];
                end
            end
            avail[N_ELEM-1] = '0;
        end
    end

endmodule

// ===== hdl/p8cr_datapath.sv =====
// single-pass logic for all commands of the permutation unit
module p8cr_datapath (
    input  p8cr_pkg::op_beat_t  op,
    output p8cr_pkg::res_beat_t res
);
    import p8cr_pkg::*;

    logic [PERM_W-1:0] unrank_perm;

    p8cr_unrank u_unrank (
        .perm_index (op.perm_index),
        .perm       (unrank_perm)
    );

    always_comb
    begin
        logic [ENT_W-1:0]  ea [N_ELEM];
        logic [ENT_W-1:0]  dgt [N_ELEM];
        logic [PERM_W-1:0] comp_ab;
        logic [PERM_W-1:0] comp_bc;
        logic [PERM_W-1:0] comp_abc;
        logic [PERM_W-1:0] inv;
        logic [RANK_W-1:0] rank_sum;
        logic [N_ELEM-1:0] used;
        logic              par;
        logic              bad;

        comp_ab  = '0;
        comp_bc  = '0;
        comp_abc = '0;
        inv      = '0;
        rank_sum = '0;
        used     = '0;
        par      = 1'b0;

        for (int i = 0; i < N_ELEM; i++)
        begin
            ea[i] = op.perm_a[i*ENT_W +: ENT_W];
            used  = used | (N_ELEM'(1) << ea[i]);
        end
        bad = (used != {N_ELEM{1'b1}});

        for (int i = 0; i < N_ELEM; i++)
        begin
            comp_ab[i*ENT_W +: ENT_W] =
                perm_entry(op.perm_a, perm_entry(op.perm_b, ENT_W'(i)));
            comp_bc[i*ENT_W +: ENT_W] =
                perm_entry(op.perm_b, perm_entry(op.perm_c, ENT_W'(i)));
        end
        for (int i = 0; i < N_ELEM; i++)
        begin
            comp_abc[i*ENT_W +: ENT_W] =
                perm_entry(op.perm_a, comp_bc[i*ENT_W +: ENT_W]);
        end

        // slot k gets the OR of every position that points at it
        for (int k = 0; k < N_ELEM; k++)
        begin
            for (int i = 0; i < N_ELEM; i++)
            begin
                if (ea[i] == ENT_W'(k))
                begin
                    inv[k*ENT_W +: ENT_W] = inv[k*ENT_W +: ENT_W] | ENT_W'(i);
                end
            end
        end

        // lehmer digit: later entries not above this one (an inversion count
        // for a true permutation, so its bits also give the parity)
        for (int i = 0; i < N_ELEM; i++)
        begin
            dgt[i] = '0;
            for (int j = 0; j < N_ELEM; j++)
            begin
                if (j > i && ea[j] <= ea[i])
                begin
                    dgt[i] = dgt[i] + ENT_W'(1);
                end
            end
            rank_sum = rank_sum + RANK_W'({13'd0, dgt[i]} * RANK_WEIGHT[i]);
            par      = par ^ dgt[i][0];
        end

        res = '0;
        res.not_perm = bad;
        unique case (op.cmd)
            CMD_COMPOSE:  res.perm_out   = comp_ab;
            CMD_COMPOSE3: res.perm_out   = comp_abc;
            CMD_INVERSE:  res.perm_out   = inv;
            CMD_RANK:     res.rank_out   = rank_sum;
            CMD_UNRANK:   res.perm_out   = unrank_perm;
            CMD_PARITY:   res.odd_parity = par & ~bad;
            default:      res.perm_out   = '0;
        endcase
    end

endmodule

// ===== hdl/perm8_compose_rank_unit.sv =====
// top level of the permutation unit: input stage, datapath, result register
// Permutation unit for 8 elements packed as eight 3-bit entries. Each beat on
// op carries a command (compose, compose3, inverse, rank, unrank, parity) and
// its operands; each accepted beat yields exactly one beat on res, in order.
// All work for a beat is done in one pass of combinational logic between the
// input stage register and the result register, so the unit takes one beat
// per cycle while res_ready is high. An accepted beat is held in the input
// stage register and moves to the result register, raising res_valid, once
// that register is empty or being drained. The deepest path is the unrank
// decode (constant-reciprocal multiplies followed by the eight-step
// selection). op_ready follows res_ready combinationally through the two
// register stages; the unit holds no state between beats.
module perm8_compose_rank_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    output logic                op_ready,
    input  p8cr_pkg::op_beat_t  op_data,
    output logic                res_valid,
    input  logic                res_ready,
    output p8cr_pkg::res_beat_t res_data
);
    import p8cr_pkg::*;

    logic      stg_valid_reg;
    logic      stg_valid_next;
    op_beat_t  stg_data_reg;
    logic      rslt_valid_reg;
    logic      rslt_valid_next;
    res_beat_t rslt_data_reg;
    res_beat_t rslt_data_next;
    logic      rslt_load;
    logic      op_take;

    p8cr_datapath u_datapath (
        .op  (stg_data_reg),
        .res (rslt_data_next)
    );

    // the result register takes the staged beat whenever it is empty or being drained
    assign rslt_load = stg_valid_reg && (!rslt_valid_reg || res_ready);
    assign op_ready  = !stg_valid_reg || rslt_load;
    assign op_take   = op_valid && op_ready;

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        if (op_take)
        begin
            stg_valid_next = 1'b1;
        end
        else if (rslt_load)
        begin
            stg_valid_next = 1'b0;
        end

        rslt_valid_next = rslt_valid_reg;
        if (rslt_load)
        begin
            rslt_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            rslt_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg  <= 1'b0;
            rslt_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg  <= stg_valid_next;
            rslt_valid_reg <= rslt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_take)
        begin
            stg_data_reg <= op_data;
        end
        if (rslt_load)
        begin
            rslt_data_reg <= rslt_data_next;
        end
    end

    assign res_valid = rslt_valid_reg;
    assign res_data  = rslt_data_reg;

`ifndef ASSERT_OFF
    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !stg_valid_reg |-> op_ready)
        else $error("input stage empty but op_ready low");

    a_stage_advances: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid_reg && !rslt_valid_reg |=> res_valid)
        else $error("staged beat did not reach the result register");

    a_parity_valid_perm: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.odd_parity |-> !res_data.not_perm)
        else $error("odd parity reported for a non-permutation");

    a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.rank_out < N_PERMS)
        else $error("rank out of range");
`endif

endmodule

// ===== tb/tb_perm8_compose_rank_unit.sv =====
// self-checking testbench for perm8_compose_rank_unit with its own result predictor
module tb_perm8_compose_rank_unit;

    import p8cr_pkg::*;

    localparam logic [2:0]        CMD_SPARE6   = 3'd6;
    localparam logic [2:0]        CMD_SPARE7   = 3'd7;
    localparam logic [31:0]       NIBBLE_ONES  = 32'h11111111;
    localparam logic [31:0]       FREE_LIST    = 32'h76543210;
    localparam logic [PERM_W-1:0] IDENT_PERM   = 24'o76543210;
    localparam logic [PERM_W-1:0] REVERSE_PERM = 24'o01234567;
    localparam int                RANDOM_ITEMS = 330;
    localparam int                TIME_LIMIT   = 400000;

    logic      clk;
    logic      rst_n;
    logic      op_valid;
    logic      op_ready;
    op_beat_t  op_data;
    logic      res_valid;
    logic      res_ready;
    res_beat_t res_data;

    res_beat_t pending_results[$];
    int        fail_count;
    int        res_count;
    int        snd_idle_pct;
    int        rcv_idle_pct;
    int        hold_left;

    perm8_compose_rank_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op_data   (op_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #TIME_LIMIT;
        $display("perm8_compose_rank_unit test failed");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic logic [PERM_W-1:0] compose_perm(logic [PERM_W-1:0] a,
                                                       logic [PERM_W-1:0] b);
        logic [PERM_W-1:0] r;
        r = '0;
        for (int i = 0; i < N_ELEM; i++)
            r[3*i +: 3] = a[3*int'(b[3*i +: 3]) +: 3];
        return r;
    endfunction

    function automatic logic [PERM_W-1:0] invert_perm(logic [PERM_W-1:0] a);
        logic [PERM_W-1:0] r;
        r = '0;
        // colliding slots collect the or of their indices
        for (int i = 0; i < N_ELEM; i++)
            r[3*int'(a[3*i +: 3]) +: 3] = r[3*int'(a[3*i +: 3]) +: 3] | 3'(i);
        return r;
    endfunction

    function automatic logic [RANK_W-1:0] lehmer_rank(logic [PERM_W-1:0] a);
        logic [31:0] acc;
        logic [31:0] seen;
        int          sh;
        acc  = '0;
        seen = '0;
        for (int i = N_ELEM - 1; i >= 0; i--)
        begin
            sh   = 4 * int'(a[3*i +: 3]);
            acc  = ((32'(8 - i) * acc) + ((seen >> sh) & 32'hf)) & 32'hffff;
            seen = seen + (NIBBLE_ONES << sh);
        end
        return acc[RANK_W-1:0];
    endfunction

    function automatic logic [PERM_W-1:0] lehmer_unrank(logic [IDX_W-1:0] index);
        int          idx;
        int          sh;
        logic [31:0] avail;
        logic [31:0] hi;
        logic [PERM_W-1:0] r;
        idx   = int'(index) % int'(N_PERMS);
        avail = FREE_LIST;
        r     = '0;
        for (int n = N_ELEM; n > 0; n--)
        begin
            sh = (idx % n) * 4;
            hi = 32'hffffffff << sh;
            r[3*(N_ELEM - n) +: 3] = avail[sh +: 3];
            avail = (avail & ~hi) | ((avail >> 4) & hi);
            idx   = idx / n;
        end
        return r;
    endfunction

    function automatic logic has_repeat(logic [PERM_W-1:0] a);
        logic [N_ELEM-1:0] used;
        used = '0;
        for (int i = 0; i < N_ELEM; i++)
            used[a[3*i +: 3]] = 1'b1;
        return used != 8'hff;
    endfunction

    function automatic logic odd_cycles(logic [PERM_W-1:0] a);
        logic [N_ELEM-1:0] visited;
        logic              odd;
        int                p;
        visited = '0;
        odd     = 1'b0;
        for (int i = 0; i < N_ELEM; i++)
        begin
            if (!visited[i])
            begin
                visited[i] = 1'b1;
                p = i;
                for (int k = 0; k < N_ELEM; k++)
                begin
                    p = int'(a[3*p +: 3]);
                    if (p == i)
                        break;
                    visited[p] = 1'b1;
                    odd = ~odd;
                end
            end
        end
        return odd;
    endfunction

    function automatic res_beat_t predict_result(op_beat_t op);
        res_beat_t r;
        r = '0;
        r.not_perm = has_repeat(op.perm_a);
        case (op.cmd)
            CMD_COMPOSE:  r.perm_out = compose_perm(op.perm_a, op.perm_b);
            CMD_COMPOSE3: r.perm_out = compose_perm(op.perm_a,
                                                    compose_perm(op.perm_b, op.perm_c));
            CMD_INVERSE:  r.perm_out = invert_perm(op.perm_a);
            CMD_RANK:     r.rank_out = lehmer_rank(op.perm_a);
            CMD_UNRANK:   r.perm_out = lehmer_unrank(op.perm_index);
            CMD_PARITY:   r.odd_parity = r.not_perm ? 1'b0 : odd_cycles(op.perm_a);
            default:      ;
        endcase
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic op_beat_t make_op(logic [2:0] cmd, logic [PERM_W-1:0] a,
                                         logic [PERM_W-1:0] b, logic [PERM_W-1:0] c,
                                         logic [IDX_W-1:0] index);
        op_beat_t op;
        op.cmd        = cmd;
        op.perm_a     = a;
        op.perm_b     = b;
        op.perm_c     = c;
        op.perm_index = index;
        return op;
    endfunction

    function automatic logic [PERM_W-1:0] shuffled_perm();
        int                v[N_ELEM];
        int                j;
        int                t;
        logic [PERM_W-1:0] r;
        for (int i = 0; i < N_ELEM; i++)
            v[i] = i;
        for (int i = N_ELEM - 1; i > 0; i--)
        begin
            j    = $urandom_range(i);
            t    = v[i];
            v[i] = v[j];
            v[j] = t;
        end
        for (int i = 0; i < N_ELEM; i++)
            r[3*i +: 3] = 3'(v[i]);
        return r;
    endfunction

    // mostly true permutations, some raw bit patterns and some with one slot spoiled
    function automatic logic [PERM_W-1:0] operand_perm();
        logic [PERM_W-1:0] r;
        int                pick;
        pick = $urandom_range(99);
        r    = shuffled_perm();
        if (pick < 8)
            r = PERM_W'($urandom);
        else if (pick < 15)
            r[3*$urandom_range(N_ELEM - 1) +: 3] = 3'($urandom_range(7));
        return r;
    endfunction

    function automatic op_beat_t random_op();
        logic [2:0]       cmd;
        logic [IDX_W-1:0] index;
        cmd = ($urandom_range(99) < 4) ? (($urandom_range(1) != 0) ? CMD_SPARE7 : CMD_SPARE6)
                                       : 3'($urandom_range(5));
        index = ($urandom_range(1) != 0) ? IDX_W'($urandom_range(65535))
                                         : IDX_W'($urandom_range(int'(N_PERMS) - 1));
        return make_op(cmd, operand_perm(), operand_perm(), operand_perm(), index);
    endfunction

    // entered and left at a falling edge
    task automatic send_op(op_beat_t op);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            op_valid <= 1'b0;
            @(negedge clk);
        end
        op_valid <= 1'b1;
        op_data  <= op;
        do
            @(posedge clk);
        while (!op_ready);
        @(negedge clk);
    endtask

    task automatic go_quiet();
        op_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        go_quiet();
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
                 res_count, what, got, want);
        fail_count++;
    endtask

    // ---------------- receiver and checker ----------------

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            res_ready <= 1'b0;
            hold_left--;
        end
        else
            res_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        res_beat_t want;
        if (rst_n)
        begin
            if (op_valid && op_ready)
                pending_results.push_back(predict_result(op_data));
            if (res_valid && res_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected beat", 32'(res_data), 32'd0);
                else
                begin
                    want = pending_results.pop_front();
                    if (res_data.perm_out !== want.perm_out)
                        report_mismatch("perm_out", 32'(res_data.perm_out), 32'(want.perm_out));
                    if (res_data.rank_out !== want.rank_out)
                        report_mismatch("rank_out", 32'(res_data.rank_out), 32'(want.rank_out));
                    if (res_data.odd_parity !== want.odd_parity)
                        report_mismatch("odd_parity", 32'(res_data.odd_parity),
                                        32'(want.odd_parity));
                    if (res_data.not_perm !== want.not_perm)
                        report_mismatch("not_perm", 32'(res_data.not_perm), 32'(want.not_perm));
                end
                res_count++;
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_each_command();
        logic [PERM_W-1:0] p;
        logic [PERM_W-1:0] q;
        logic [PERM_W-1:0] s;
        p = shuffled_perm();
        q = shuffled_perm();
        s = shuffled_perm();
        send_op(make_op(CMD_COMPOSE, p, q, s, 16'd0));
        send_op(make_op(CMD_COMPOSE3, p, q, s, 16'd0));
        send_op(make_op(CMD_INVERSE, p, q, s, 16'd0));
        send_op(make_op(CMD_RANK, p, q, s, 16'd0));
        send_op(make_op(CMD_UNRANK, p, q, s, 16'd12345));
        send_op(make_op(CMD_PARITY, p, q, s, 16'd0));
        send_op(make_op(CMD_SPARE6, p, q, s, 16'hffff));
        send_op(make_op(CMD_SPARE7, 24'hffffff, q, s, 16'hffff));
    endtask

    task automatic test_extreme_perms();
        send_op(make_op(CMD_COMPOSE, IDENT_PERM, REVERSE_PERM, '0, '0));
        send_op(make_op(CMD_COMPOSE3, REVERSE_PERM, REVERSE_PERM, REVERSE_PERM, '0));
        send_op(make_op(CMD_RANK, IDENT_PERM, '0, '0, '0));
        send_op(make_op(CMD_RANK, REVERSE_PERM, '1, '1, '1));
        send_op(make_op(CMD_PARITY, REVERSE_PERM, '0, '0, '0));
        send_op(make_op(CMD_PARITY, IDENT_PERM, '1, '1, '1));
    endtask

    task automatic test_non_permutation();
        send_op(make_op(CMD_INVERSE, 24'h000000, '0, '0, '0));
        send_op(make_op(CMD_INVERSE, 24'o00112233, '0, '0, '0));
        send_op(make_op(CMD_RANK, 24'hffffff, '0, '0, '0));
        send_op(make_op(CMD_RANK, 24'o77000077, '0, '0, '0));
        send_op(make_op(CMD_PARITY, 24'o76543211, '0, '0, '0));
        send_op(make_op(CMD_COMPOSE, 24'hffffff, 24'h000000, '1, '0));
    endtask

    task automatic test_index_wrap();
        send_op(make_op(CMD_UNRANK, '0, '0, '0, 16'd0));
        send_op(make_op(CMD_UNRANK, '1, '1, '1, 16'd40319));
        send_op(make_op(CMD_UNRANK, '0, '0, '0, 16'd40320));
        send_op(make_op(CMD_UNRANK, '0, '0, '0, 16'd65535));
    endtask

    task automatic test_random_traffic(int snd_pct, int rcv_pct, int count);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        for (int n = 0; n < count; n++)
            send_op(random_op());
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_left    = 60;
        for (int n = 0; n < 30; n++)
            send_op(random_op());
        wait_drained();
        for (int n = 0; n < 10; n++)
            send_op(random_op());
    endtask

    task automatic finish_run();
        int guard;
        go_quiet();
        guard = 0;
        while (pending_results.size() != 0 && guard < 5000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (8) @(negedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never arrived", 32'(pending_results.size()), 32'd0);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        op_valid     = 1'b0;
        op_data      = '0;
        res_ready    = 1'b0;
        fail_count   = 0;
        res_count    = 0;
        snd_idle_pct = 16;
        rcv_idle_pct = 82;
        hold_left    = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_each_command();
        test_extreme_perms();
        test_non_permutation();
        test_index_wrap();
        wait_drained();

        test_random_traffic(16, 82, RANDOM_ITEMS);
        wait_drained();
        test_random_traffic(82, 16, RANDOM_ITEMS);
        test_backpressure();
        test_random_traffic(0, 0, RANDOM_ITEMS);
        finish_run();

        if (fail_count == 0)
            $display("perm8_compose_rank_unit test passed");
        else
            $display("perm8_compose_rank_unit test failed");
        $finish;
    end

endmodule
